/* sv/hpm_pkg.sv */
`default_nettype none

package hpm_pkg;

    // defaults for the top level parameters
    localparam int DEF_SLOTS      = 1024;
    localparam int DEF_POOL_NODES = 2048;
    localparam int DEF_PAGE_BITS  = 20;
    localparam int DEF_VALUE_BITS = 32;

    // bucket index mixes the page with its upper part
    localparam int HASH_SHIFT = 10;

    typedef enum logic [7:0] {
        ST_CLEAR  = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_HEAD   = 8'b0000_0100,
        ST_NODE   = 8'b0000_1000,
        ST_EXEC   = 8'b0001_0000,
        ST_FREE   = 8'b0010_0000,
        ST_ALLOC  = 8'b0100_0000,
        ST_RESULT = 8'b1000_0000
    } hpm_state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic clr_step;
        logic accept;
        logic head_take;
        logic walk_step;
        logic mark_hit;
        logic wr_data;
        logic unlink;
        logic free_push;
        logic alloc_rd;
        logic alloc_free;
        logic alloc_fresh;
        logic mark_full;
        logic load_out;
    } hpm_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic clr_last;
        logic head_is_node;
        logic key_match;
        logic link_is_node;
        logic free_is_node;
        logic fresh_avail;
        logic val_nz;
        logic kind;
        logic hit;
    } hpm_status_t;

endpackage

`default_nettype wire

/* sv/hpm_ctrl.sv */
`default_nettype none

module hpm_ctrl import hpm_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  wire logic        m_ready,
    input  wire hpm_status_t status,
    output hpm_cmd_t         cmd
);

    hpm_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    // sequencer over clear sweep, head read, chain walk, update and result
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD: begin
                cmd.head_take = 1'b1;
                state_next = status.head_is_node ? ST_NODE : ST_EXEC;
            end
            ST_NODE: begin
                if (status.key_match) begin
                    cmd.mark_hit = 1'b1;
                    state_next   = ST_EXEC;
                end else if (status.link_is_node) begin
                    cmd.walk_step = 1'b1;
                end else begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_RESULT;
                if (status.kind) begin
                    if (status.hit) begin
                        if (status.val_nz) begin
                            cmd.wr_data = 1'b1;
                        end else begin
                            cmd.unlink = 1'b1;
                            state_next = ST_FREE;
                        end
                    end else if (status.val_nz) begin
                        if (status.free_is_node) begin
                            cmd.alloc_rd = 1'b1;
                            state_next   = ST_ALLOC;
                        end else if (status.fresh_avail) begin
                            cmd.alloc_fresh = 1'b1;
                        end else begin
                            cmd.mark_full = 1'b1;
                        end
                    end
                end
            end
            ST_FREE: begin
                cmd.free_push = 1'b1;
                state_next    = ST_RESULT;
            end
            ST_ALLOC: begin
                cmd.alloc_free = 1'b1;
                state_next     = ST_RESULT;
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // output valid flag
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

/* sv/hpm_dp.sv */
`default_nettype none

module hpm_dp import hpm_pkg::*; #(
    parameter int SLOTS      = DEF_SLOTS,
    parameter int POOL_NODES = DEF_POOL_NODES,
    parameter int PAGE_BITS  = DEF_PAGE_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire hpm_cmd_t              cmd,
    output hpm_status_t                status,
    input  wire logic                  s_kind,
    input  wire logic                  s_table_select,
    input  wire logic [PAGE_BITS-1:0]  s_page,
    input  wire logic [VALUE_BITS-1:0] s_map_value,
    output logic [VALUE_BITS-1:0]      m_found_value,
    output logic                       m_hit,
    output logic                       m_pool_full
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int HEAD_N = 2 * SLOTS;
    localparam int NODE_W = $clog2(POOL_NODES);
    localparam int LINK_W = $clog2(POOL_NODES + 1);
    localparam int HASH_W = (PAGE_BITS > SLOT_W) ? PAGE_BITS : SLOT_W;
    localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_NODES);

    // memories
    logic [LINK_W-1:0]     head_mem [HEAD_N];
    logic [PAGE_BITS-1:0]  key_mem  [POOL_NODES];
    logic [VALUE_BITS-1:0] data_mem [POOL_NODES];
    logic [LINK_W-1:0]     link_mem [POOL_NODES];

    // transaction registers
    logic                  kind_reg;
    logic [PAGE_BITS-1:0]  page_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [SLOT_W:0]       head_addr_reg;
    logic                  hit_reg, hit_next;
    logic                  full_reg, full_next;

    // walk registers
    logic [LINK_W-1:0]     head_q_reg;
    logic [LINK_W-1:0]     head_val_reg;
    logic [LINK_W-1:0]     cur_reg;
    logic [LINK_W-1:0]     prev_reg;
    logic [PAGE_BITS-1:0]  key_q_reg;
    logic [VALUE_BITS-1:0] data_q_reg;
    logic [LINK_W-1:0]     link_q_reg;

    // allocator and clear sweep
    logic [LINK_W-1:0]     free_head_reg, free_head_next;
    logic [LINK_W-1:0]     fresh_reg, fresh_next;
    logic [SLOT_W:0]       clr_cnt_reg, clr_cnt_next;

    logic [PAGE_BITS-1:0]  hash_mix;
    logic [HASH_W-1:0]     hash_ext;
    logic [SLOT_W:0]       in_head_addr;
    logic                  prev_is_node;
    logic                  do_alloc;
    logic [LINK_W-1:0]     new_node;

    logic                  head_we;
    logic [SLOT_W:0]       head_waddr;
    logic [LINK_W-1:0]     head_wdata;
    logic                  node_re;
    logic [LINK_W-1:0]     node_raddr;
    logic                  link_we;
    logic [LINK_W-1:0]     link_waddr;
    logic [LINK_W-1:0]     link_wdata;
    logic                  data_we;
    logic [LINK_W-1:0]     data_waddr;

    // bucket index of the incoming page
    assign hash_mix     = s_page ^ (s_page >> HASH_SHIFT);
    assign hash_ext     = HASH_W'(hash_mix);
    assign in_head_addr = {s_table_select, hash_ext[SLOT_W-1:0]};

    assign prev_is_node = (prev_reg < NIL);
    assign do_alloc     = cmd.alloc_free | cmd.alloc_fresh;
    assign new_node     = cmd.alloc_free ? free_head_reg : fresh_reg;

    // status back to the controller
    always_comb begin
        status.clr_last     = (clr_cnt_reg == {(SLOT_W + 1){1'b1}});
        status.head_is_node = (head_q_reg < NIL);
        status.key_match    = (key_q_reg == page_reg);
        status.link_is_node = (link_q_reg < NIL);
        status.free_is_node = (free_head_reg < NIL);
        status.fresh_avail  = (fresh_reg < NIL);
        status.val_nz       = (val_reg != '0);
        status.kind         = kind_reg;
        status.hit          = hit_reg;
    end

    // head table write port
    always_comb begin
        head_we    = 1'b0;
        head_waddr = head_addr_reg;
        head_wdata = NIL;
        if (cmd.clr_step) begin
            head_we    = 1'b1;
            head_waddr = clr_cnt_reg;
        end else if (cmd.unlink && !prev_is_node) begin
            head_we    = 1'b1;
            head_wdata = link_q_reg;
        end else if (do_alloc) begin
            head_we    = 1'b1;
            head_wdata = new_node;
        end
    end

    // node read port
    always_comb begin
        node_re    = 1'b0;
        node_raddr = head_q_reg;
        if (cmd.head_take) begin
            node_re = status.head_is_node;
        end else if (cmd.walk_step) begin
            node_re    = status.link_is_node;
            node_raddr = link_q_reg;
        end else if (cmd.alloc_rd) begin
            node_re    = 1'b1;
            node_raddr = free_head_reg;
        end
    end

    // node link and data write ports
    always_comb begin
        link_we    = 1'b0;
        link_waddr = prev_reg;
        link_wdata = link_q_reg;
        if (cmd.unlink && prev_is_node) begin
            link_we = 1'b1;
        end else if (cmd.free_push) begin
            link_we    = 1'b1;
            link_waddr = cur_reg;
            link_wdata = free_head_reg;
        end else if (do_alloc) begin
            link_we    = 1'b1;
            link_waddr = new_node;
            link_wdata = head_val_reg;
        end
        data_we    = cmd.wr_data | do_alloc;
        data_waddr = cmd.wr_data ? cur_reg : new_node;
    end

    always_ff @(posedge aclk) begin
        if (head_we) begin
            head_mem[head_waddr] <= head_wdata;
        end
        if (cmd.accept) begin
            head_q_reg <= head_mem[in_head_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (do_alloc) begin
            key_mem[new_node[NODE_W-1:0]] <= page_reg;
        end
        if (data_we) begin
            data_mem[data_waddr[NODE_W-1:0]] <= val_reg;
        end
        if (link_we) begin
            link_mem[link_waddr[NODE_W-1:0]] <= link_wdata;
        end
        if (node_re) begin
            key_q_reg  <= key_mem[node_raddr[NODE_W-1:0]];
            data_q_reg <= data_mem[node_raddr[NODE_W-1:0]];
            link_q_reg <= link_mem[node_raddr[NODE_W-1:0]];
        end
    end

    // transaction capture and chain position
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            kind_reg      <= s_kind;
            page_reg      <= s_page;
            val_reg       <= s_map_value;
            head_addr_reg <= in_head_addr;
        end
        if (cmd.head_take) begin
            cur_reg      <= head_q_reg;
            prev_reg     <= NIL;
            head_val_reg <= head_q_reg;
        end else if (cmd.walk_step) begin
            cur_reg  <= link_q_reg;
            prev_reg <= cur_reg;
        end
        hit_reg  <= hit_next;
        full_reg <= full_next;
        if (cmd.load_out) begin
            m_found_value <= (!kind_reg && hit_reg) ? data_q_reg : '0;
            m_hit         <= hit_reg;
            m_pool_full   <= full_reg;
        end
    end

    always_comb begin
        hit_next  = hit_reg;
        full_next = full_reg;
        if (cmd.accept) begin
            hit_next  = 1'b0;
            full_next = 1'b0;
        end
        if (cmd.mark_hit) begin
            hit_next = 1'b1;
        end
        if (cmd.mark_full) begin
            full_next = 1'b1;
        end
    end

    // free list, fresh counter, clear sweep
    always_comb begin
        free_head_next = free_head_reg;
        fresh_next     = fresh_reg;
        clr_cnt_next   = clr_cnt_reg;
        if (cmd.alloc_free) begin
            free_head_next = link_q_reg;
        end else if (cmd.free_push) begin
            free_head_next = cur_reg;
        end
        if (cmd.alloc_fresh) begin
            fresh_next = fresh_reg + 1'b1;
        end
        if (cmd.clr_step) begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_head_reg <= NIL;
            fresh_reg     <= '0;
            clr_cnt_reg   <= '0;
        end else begin
            free_head_reg <= free_head_next;
            fresh_reg     <= fresh_next;
            clr_cnt_reg   <= clr_cnt_next;
        end
    end

endmodule

`default_nettype wire

/* sv/hashed_page_map_dual_table.sv */
// channel  | direction | ports
// ---------+-----------+-----------------------------------------------------
// request  | in        | s_valid s_ready s_kind s_table_select s_page s_map_value
// result   | out       | m_valid m_ready m_found_value m_hit m_pool_full
//
// one transaction at a time: the sequencer reads the bucket head, walks the
// chain node by node through the single-port node memory, then updates, with
// an extra step for an unmap or a free-list allocation, and loads the result
// after reset a clearing pass writes all 2*SLOTS bucket heads, one a cycle,
// before the first request is taken
// the result sits in an output register, so a stalled m_ready holds only
// the next transaction's completion

`default_nettype none

module hashed_page_map_dual_table import hpm_pkg::*; #(
    parameter int SLOTS      = DEF_SLOTS,
    parameter int POOL_NODES = DEF_POOL_NODES,
    parameter int PAGE_BITS  = DEF_PAGE_BITS,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_kind,
    input  wire logic                  s_table_select,
    input  wire logic [PAGE_BITS-1:0]  s_page,
    input  wire logic [VALUE_BITS-1:0] s_map_value,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [VALUE_BITS-1:0]      m_found_value,
    output logic                       m_hit,
    output logic                       m_pool_full
);

    hpm_cmd_t    cmd;
    hpm_status_t status;

    // sequencer
    hpm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // tables, node pool and allocator
    hpm_dp #(
        .SLOTS      (SLOTS),
        .POOL_NODES (POOL_NODES),
        .PAGE_BITS  (PAGE_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_kind         (s_kind),
        .s_table_select (s_table_select),
        .s_page         (s_page),
        .s_map_value    (s_map_value),
        .m_found_value  (m_found_value),
        .m_hit          (m_hit),
        .m_pool_full    (m_pool_full)
    );

    // a returned value only comes from a hit
    a_found_needs_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_found_value == '0 || m_hit))
        else $error("nonzero value without hit");

    // a dropped insert never follows a hit
    a_full_not_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_pool_full |-> !m_hit && m_found_value == '0)
        else $error("pool_full together with hit or value");

    // no request is taken while a result is being loaded
    a_no_accept_on_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !m_valid || $stable(m_hit) || $past(m_ready))
        else $error("result changed while request was taken");

endmodule

`default_nettype wire

/* verif/page_map_checker.sv */
`timescale 1ns / 100ps

module page_map_checker import hpm_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic        s_kind,
    input  wire logic        s_table_select,
    input  wire logic [19:0] s_page,
    input  wire logic [31:0] s_map_value,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [31:0] m_found_value,
    input  wire logic        m_hit,
    input  wire logic        m_pool_full,
    output int               fail_count,
    output int               pending_count
);

    localparam int NSLOT = DEF_SLOTS;
    localparam int NPOOL = DEF_POOL_NODES;
    localparam int NIL   = NPOOL;

    typedef struct packed {
        logic [31:0] found;
        logic        hit;
        logic        full;
    } lookup_result_t;

    // shadow copy of both maps and the shared pool
    int          head_tab [2][NSLOT];
    logic [19:0] key_mem  [NPOOL];
    logic [31:0] data_mem [NPOOL];
    int          link_mem [NPOOL];
    int          free_top;
    int          fresh_used;

    lookup_result_t awaited_results[$];

    function automatic int bucket_of(logic [19:0] pg);
        logic [19:0] h;
        h = pg ^ (pg >> HASH_SHIFT);
        return int'(h) & (NSLOT - 1);
    endfunction

    // apply one transaction to the shadow maps
    function automatic lookup_result_t apply_page_op(logic kind, logic sel,
                                                     logic [19:0] pg,
                                                     logic [31:0] val);
        lookup_result_t r;
        int slot, prev, cur, steps, n;
        r = '0;
        slot = bucket_of(pg);
        prev = NIL;
        cur = head_tab[sel][slot];
        steps = 0;
        while (cur < NPOOL && steps < NPOOL) begin
            if (key_mem[cur] == pg) begin
                r.hit = 1'b1;
                break;
            end
            prev = cur;
            cur = link_mem[cur];
            steps++;
        end
        if (!kind) begin
            if (r.hit) r.found = data_mem[cur];
        end else if (r.hit) begin
            if (val != 0) begin
                data_mem[cur] = val;
            end else begin
                if (prev < NPOOL) link_mem[prev] = link_mem[cur];
                else head_tab[sel][slot] = link_mem[cur];
                link_mem[cur] = free_top;
                free_top = cur;
            end
        end else if (val != 0) begin
            n = NIL;
            if (free_top < NPOOL) begin
                n = free_top;
                free_top = link_mem[n];
            end else if (fresh_used < NPOOL) begin
                n = fresh_used;
                fresh_used++;
            end
            if (n < NPOOL) begin
                key_mem[n] = pg;
                data_mem[n] = val;
                link_mem[n] = head_tab[sel][slot];
                head_tab[sel][slot] = n;
            end else begin
                r.full = 1'b1;
            end
        end
        return r;
    endfunction

    assign pending_count = awaited_results.size();

    // predict on request, compare on result
    always @(posedge aclk) begin
        lookup_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < NSLOT; i++) begin
                head_tab[0][i] = NIL;
                head_tab[1][i] = NIL;
            end
            free_top = NIL;
            fresh_used = 0;
            awaited_results.delete();
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready)
                awaited_results.push_back(apply_page_op(s_kind, s_table_select,
                                                        s_page, s_map_value));
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result transaction at %0t", $time);
                    fail_count <= fail_count + 1;
                end else begin
                    want = awaited_results.pop_front();
                    if (want.found !== m_found_value || want.hit !== m_hit
                        || want.full !== m_pool_full) begin
                        if (fail_count < 10)
                            $display("bad result at %0t: exp val=%h hit=%b full=%b, got val=%h hit=%b full=%b",
                                     $time, want.found, want.hit, want.full,
                                     m_found_value, m_hit, m_pool_full);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_kind = 1'b0;
    logic        s_table_select = 1'b0;
    logic [19:0] s_page = '0;
    logic [31:0] s_map_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_found_value;
    logic        m_hit;
    logic        m_pool_full;
    int          fail_count;
    int          pending_count;
    int          cycle_count = 0;
    bit          hold_result = 1'b0;

    localparam int CYCLE_LIMIT = 400000;

    // recently touched pages, reused so lookups and unmaps hit
    logic [19:0] page_pool[$];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    hashed_page_map_dual_table DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_table_select(s_table_select), .s_page(s_page), .s_map_value(s_map_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_found_value(m_found_value),
        .m_hit(m_hit), .m_pool_full(m_pool_full)
    );

    page_map_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_table_select(s_table_select), .s_page(s_page), .s_map_value(s_map_value),
        .m_valid(m_valid), .m_ready(m_ready), .m_found_value(m_found_value),
        .m_hit(m_hit), .m_pool_full(m_pool_full),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side back-pressure
    initial begin
        int g;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_result) begin
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_result = 1'b0;
            end
            g = gap_len();
            if (g > 0 && cycle_count > 4000 && cycle_count < 9000) g = 0;
            m_ready <= (g == 0);
            repeat (g > 0 ? g : 1) @(posedge aclk);
        end
    end

    task automatic send_op(logic kind, logic sel, logic [19:0] pg, logic [31:0] val);
        s_valid <= 1'b1;
        s_kind <= kind;
        s_table_select <= sel;
        s_page <= pg;
        s_map_value <= val;
        @(posedge aclk iff s_ready);
        if (page_pool.size() < 64) page_pool.push_back(pg);
        else page_pool[$urandom_range(0, 63)] = pg;
    endtask

    task automatic idle_gap();
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    initial begin
        logic [19:0] pg;
        logic [31:0] val;
        int          roll;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, both maps, hit/miss, overwrite, unmap
        send_op(1'b0, 1'b0, 20'h00000, 32'h0);
        send_op(1'b1, 1'b0, 20'h00000, 32'hFFFFFFFF);
        send_op(1'b0, 1'b0, 20'h00000, 32'h0);
        send_op(1'b0, 1'b1, 20'h00000, 32'hFFFFFFFF);
        send_op(1'b1, 1'b1, 20'hFFFFF, 32'h00000001);
        send_op(1'b1, 1'b1, 20'hFFFFF, 32'h80000000);
        send_op(1'b0, 1'b1, 20'hFFFFF, 32'h0);
        // colliding pages share a bucket
        send_op(1'b1, 1'b0, 20'h00401, 32'h11111111);
        send_op(1'b1, 1'b0, 20'h00000 ^ 20'h00400 ^ 20'h00001, 32'h22222222);
        send_op(1'b1, 1'b0, 20'h00802, 32'h33333333);
        send_op(1'b0, 1'b0, 20'h00401, 32'h0);
        // unmap middle and head of chain, unmap of absent page
        send_op(1'b1, 1'b0, 20'h00401, 32'h0);
        send_op(1'b1, 1'b0, 20'h00802, 32'h0);
        send_op(1'b1, 1'b0, 20'h12345, 32'h0);
        send_op(1'b0, 1'b0, 20'h00401, 32'h0);
        // insert reuses free list nodes
        send_op(1'b1, 1'b1, 20'hABCDE, 32'h5A5A5A5A);
        send_op(1'b1, 1'b1, 20'h54321, 32'hA5A5A5A5);
        send_op(1'b0, 1'b1, 20'h54321, 32'h0);
        send_op(1'b1, 1'b1, 20'hFFFFF, 32'h0);

        // random traffic, hold-off of the result side near the start
        for (int i = 0; i < 330; i++) begin
            if (i == 40) hold_result = 1'b1;
            roll = $urandom_range(0, 9);
            if (page_pool.size() > 0 && roll < 6)
                pg = page_pool[$urandom_range(0, page_pool.size() - 1)];
            else
                pg = 20'($urandom());
            case ($urandom_range(0, 3))
                0: val = 32'h0;
                1: val = 32'($urandom_range(1, 255));
                default: val = $urandom();
            endcase
            send_op(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pg, val);
            idle_gap();
        end

        // burst of inserts, then mixed traffic over the filled maps
        for (int i = 0; i < 250; i++) begin
            send_op(1'b1, 1'($urandom_range(0, 1)), 20'($urandom()),
                    32'($urandom()) | 32'h1);
            if (i % 16 == 0) idle_gap();
        end
        for (int i = 0; i < 50; i++) begin
            pg = page_pool.size() > 0 && $urandom_range(0, 1)
                 ? page_pool[$urandom_range(0, page_pool.size() - 1)] : 20'($urandom());
            send_op(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pg,
                    $urandom_range(0, 2) == 0 ? 32'h0 : $urandom());
            idle_gap();
        end
        s_valid <= 1'b0;

        // drain
        @(posedge aclk iff (pending_count == 0));
        repeat (50) @(posedge aclk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
